@@ hw/rtl/pbd_pkg.sv @@
// pbd_pkg: shared types and constants of the packbits plane decoder
// used by pbd_front, pbd_queue, pbd_back and packbits_plane_decoder
package pbd_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam int CfgIndexW = 8;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] RegLineWidth  = 8'd0;
  localparam logic [CfgIndexW-1:0] RegLineCount  = 8'd1;
  localparam logic [CfgIndexW-1:0] RegByteStride = 8'd2;
  localparam logic [CfgIndexW-1:0] RegNeg128Noop = 8'd3;

  localparam logic [7:0] HeaderNeg128 = 8'h80;

  localparam logic StatusData      = 1'b0;
  localparam logic StatusTruncated = 1'b1;

  // classified stream byte, as queued between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
    logic       is_neg;
    logic       is_neg128;
  } token_t;

  typedef struct packed {
    logic [14:0] line_width;
    logic [14:0] line_count;
    logic [4:0]  byte_stride;
    logic        neg128_noop;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_RUN     = 3'b010,
    PH_LITERAL = 3'b100
  } phase_t;

endpackage

@@ hw/rtl/pbd_front.sv @@
// pbd_front: input channel of the decoder, classifies each stream byte
// and pushes it into the token queue; depends on pbd_pkg
module pbd_front (
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_byte,
  input  logic                   stream_end,
  input  pbd_pkg::queue_status_t q_status,
  output logic                   push,
  output pbd_pkg::token_t        push_token
);

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_token.data      = in_byte;
    push_token.is_end    = stream_end;
    push_token.is_neg    = in_byte[7];
    push_token.is_neg128 = (in_byte == pbd_pkg::HeaderNeg128);
  end

endmodule

@@ hw/rtl/pbd_queue.sv @@
// pbd_queue: short token queue between the front and the back
// depends on pbd_pkg for the token type and depth
module pbd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pbd_pkg::token_t        push_token,
  input  logic                   pop,
  output pbd_pkg::token_t        head_token,
  output pbd_pkg::queue_status_t status
);

  pbd_pkg::token_t entries [pbd_pkg::QueueDepth];
  logic [pbd_pkg::QueuePtrW-1:0] wr_ptr;
  logic [pbd_pkg::QueuePtrW-1:0] rd_ptr;
  logic [pbd_pkg::QueueCntW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head_token   = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == pbd_pkg::QueueCntW'(pbd_pkg::QueueDepth));

endmodule

@@ hw/rtl/pbd_back.sv @@
// pbd_back: packet and line state of the decoder plus the result register
// takes classified tokens from pbd_queue; depends on pbd_pkg
module pbd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  pbd_pkg::cfg_t          cfg,
  input  pbd_pkg::queue_status_t q_status,
  input  pbd_pkg::token_t        head_token,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_value,
  output logic [7:0]             repeat_count,
  output logic [31:0]            out_offset,
  output logic                   plane_done,
  output logic                   status
);

  pbd_pkg::phase_t phase, phase_next;
  logic [7:0]  literal_left, literal_left_next;
  logic [7:0]  run_length, run_length_next;
  logic [14:0] line_bytes, line_bytes_next;
  logic [14:0] line_index, line_index_next;
  logic [31:0] write_offset, write_offset_next;
  logic        done_flag, done_flag_next;

  logic        res_valid;
  logic [7:0]  res_value;
  logic [7:0]  res_count;
  logic        res_last;
  logic        res_status;

  logic        active;
  logic        finish;
  logic [7:0]  finish_count;
  logic [15:0] total;
  logic [14:0] index_inc;
  logic [7:0]  literal_dec;
  logic [12:0] step;

  assign pop = !q_status.empty && (!out_valid || !out_stall);

  assign active = !done_flag && (cfg.line_width != '0) && (line_index < cfg.line_count);
  assign literal_dec = literal_left - 8'd1;
  assign total = {1'b0, line_bytes} + {8'd0, finish_count};
  assign index_inc = line_index + 15'd1;

  always_comb begin
    phase_next        = phase;
    literal_left_next = literal_left;
    run_length_next   = run_length;
    line_bytes_next   = line_bytes;
    line_index_next   = line_index;
    write_offset_next = write_offset;
    done_flag_next    = done_flag;
    res_valid         = 1'b0;
    res_value         = head_token.data;
    res_count         = 8'd1;
    res_last          = 1'b0;
    res_status        = pbd_pkg::StatusData;
    finish            = 1'b0;
    finish_count      = run_length;
    step              = {8'd0, cfg.byte_stride};

    if (active) begin
      if (head_token.is_end) begin
        res_valid  = 1'b1;
        res_value  = 8'd0;
        res_count  = 8'd0;
        res_status = pbd_pkg::StatusTruncated;
      end else begin
        case (phase)
          pbd_pkg::PH_HEADER: begin
            if (head_token.is_neg) begin
              if (!(head_token.is_neg128 && cfg.neg128_noop)) begin
                // 1 - h for a negative header, 2 to 129
                run_length_next = 8'd1 - head_token.data;
                phase_next      = pbd_pkg::PH_RUN;
              end
            end else begin
              run_length_next   = head_token.data + 8'd1;
              literal_left_next = head_token.data + 8'd1;
              phase_next        = pbd_pkg::PH_LITERAL;
            end
          end
          pbd_pkg::PH_RUN: begin
            res_valid    = 1'b1;
            res_count    = run_length;
            step         = 13'(run_length) * 13'(cfg.byte_stride);
            phase_next   = pbd_pkg::PH_HEADER;
            finish       = 1'b1;
            finish_count = run_length;
          end
          pbd_pkg::PH_LITERAL: begin
            res_valid         = 1'b1;
            literal_left_next = literal_dec;
            if (literal_dec == 8'd0) begin
              phase_next   = pbd_pkg::PH_HEADER;
              finish       = 1'b1;
              finish_count = run_length;
            end
          end
          default: begin
            phase_next = pbd_pkg::PH_HEADER;
          end
        endcase
        if (res_valid) begin
          write_offset_next = write_offset + {19'd0, step};
        end
        if (finish) begin
          // packet end: line ends once the count reaches the width
          if (total < {1'b0, cfg.line_width}) begin
            line_bytes_next = total[14:0];
          end else begin
            line_bytes_next = '0;
            line_index_next = index_inc;
            if (index_inc >= cfg.line_count) begin
              done_flag_next = 1'b1;
              res_last       = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= pbd_pkg::PH_HEADER;
      literal_left <= '0;
      run_length   <= '0;
      line_bytes   <= '0;
      line_index   <= '0;
      write_offset <= '0;
      done_flag    <= 1'b0;
    end else if (pop) begin
      phase        <= phase_next;
      literal_left <= literal_left_next;
      run_length   <= run_length_next;
      line_bytes   <= line_bytes_next;
      line_index   <= line_index_next;
      write_offset <= write_offset_next;
      done_flag    <= done_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded only when a token is taken
  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_value    <= res_value;
      repeat_count <= res_count;
      out_offset   <= write_offset;
      plane_done   <= res_last;
      status       <= res_status;
    end
  end

endmodule

@@ hw/rtl/packbits_plane_decoder.sv @@
// packbits_plane_decoder: top level, configuration registers and the
// front / queue / back chain; depends on pbd_pkg, pbd_front, pbd_queue, pbd_back
//
// Usage:
//   Input channel (in_valid, in_stall, in_byte, stream_end) takes one byte of
//   the compressed plane per transfer. Output channel (out_valid, out_stall,
//   out_value, repeat_count, out_offset, plane_done, status) gives one write
//   per run value or literal byte, or one error when stream_end arrives early.
//   Header bytes and ignored bytes give no output.
//   Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
//   line_width (0), line_count (1), byte_stride (2), neg128_noop (3); ready is
//   always high. Write only while the block is idle.
//   Throughput: one byte per cycle while out_stall is low, set by the back end
//   that updates packet and line state for each byte it pops. A transferred
//   byte is registered in a queue entry and then in the output register.
//   A four-entry token queue sits between the input and the back end, so the
//   input keeps taking bytes while a result waits; when out_stall holds, the
//   queue fills and in_stall rises once four bytes wait in it.
//   Reset (rst, synchronous) clears decode state, empties the queue and
//   restores line_width 1, line_count 1, byte_stride 1, neg128_noop 0.
module packbits_plane_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  input  logic                            stream_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_value,
  output logic [7:0]                      repeat_count,
  output logic [31:0]                     out_offset,
  output logic                            plane_done,
  output logic                            status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbd_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [pbd_pkg::CfgDataW-1:0]    cfg_data
);

  pbd_pkg::cfg_t          cfg;
  pbd_pkg::queue_status_t q_status;
  pbd_pkg::token_t        push_token;
  pbd_pkg::token_t        head_token;
  logic                   push;
  logic                   pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width  <= 15'd1;
      cfg.line_count  <= 15'd1;
      cfg.byte_stride <= 5'd1;
      cfg.neg128_noop <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pbd_pkg::RegLineWidth:  cfg.line_width  <= cfg_data[14:0];
        pbd_pkg::RegLineCount:  cfg.line_count  <= cfg_data[14:0];
        pbd_pkg::RegByteStride: cfg.byte_stride <= cfg_data[4:0];
        pbd_pkg::RegNeg128Noop: cfg.neg128_noop <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pbd_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .stream_end (stream_end),
    .q_status   (q_status),
    .push       (push),
    .push_token (push_token)
  );

  pbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .head_token (head_token),
    .status     (q_status)
  );

  pbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_status     (q_status),
    .head_token   (head_token),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .repeat_count (repeat_count),
    .out_offset   (out_offset),
    .plane_done   (plane_done),
    .status       (status)
  );

endmodule
